// File: design/gntc_pkg.sv
// ----------------------------------------------------------------------------
// gntc_pkg
// shared types, constants and elaboration-time tables for the terrain
// classifier pipeline
// ----------------------------------------------------------------------------
package gntc_pkg;

  // field and internal widths
  localparam int TILE_W   = 10;
  localparam int COORD_W  = 11;
  localparam int CELL_W   = 7;
  localparam int REM_W    = 5;
  localparam int FRAC_W   = 17;
  localparam int NOISE_W  = 19;
  localparam int HASH_W   = 15;
  localparam int SEED_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W   = 2;
  localparam int TBL_N    = 1 << REM_W;

  // coordinate scale and moisture offset
  localparam int NoiseDiv    = 20;
  localparam int OneQ16      = 65536;
  localparam logic [COORD_W-1:0] MOIST_OFFSET = COORD_W'(1000);
  // reciprocal of the cell size, exact for every coordinate below 2048
  localparam logic [11:0] DIV_RECIP = 12'd3277;

  // lattice hash multipliers, only the low bits reach the gradient select
  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] HASH_KS   = 32'd362437;
  localparam logic [HASH_W-1:0] KX  = HASH_KX[HASH_W-1:0];
  localparam logic [HASH_W-1:0] KY  = HASH_KY[HASH_W-1:0];
  localparam logic [HASH_W-1:0] KS  = HASH_KS[HASH_W-1:0];
  localparam int HASH_SHIFT = 13;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED   = 2'd0,
    REG_SEA    = 2'd1,
    REG_PLAINS = 2'd2,
    REG_DRY    = 2'd3
  } cfg_reg_t;

  // terrain codes
  typedef enum logic [KIND_W-1:0] {
    KIND_SEA      = 2'd0,
    KIND_PLAINS   = 2'd1,
    KIND_HILLS    = 2'd2,
    KIND_MOUNTAIN = 2'd3
  } terrain_t;

  localparam logic signed [NOISE_W-1:0] SEA_RST    = -19'sd26214;
  localparam logic signed [NOISE_W-1:0] PLAINS_RST = 19'sd6554;
  localparam logic signed [NOISE_W-1:0] DRY_RST    = -19'sd6554;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef logic [FRAC_W-1:0] frac_tbl_t [TBL_N];

  // fraction of a cell in Q0.16 for each remainder
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t tbl;
    longint    t;
    for (int r = 0; r < TBL_N; r++) begin
      t = (r < NoiseDiv) ? (longint'(r) * OneQ16) / NoiseDiv : 0;
      tbl[r] = FRAC_W'(t);
    end
    return tbl;
  endfunction

  // quintic fade of each cell fraction, products truncated toward zero
  function automatic frac_tbl_t build_fade_tbl();
    frac_tbl_t tbl;
    longint    t;
    longint    t2;
    longint    t3;
    longint    inner;
    for (int r = 0; r < TBL_N; r++) begin
      t     = (r < NoiseDiv) ? (longint'(r) * OneQ16) / NoiseDiv : 0;
      inner = (t * (6 * t - 15 * longint'(OneQ16))) / OneQ16 + 10 * longint'(OneQ16);
      t2    = (t * t) / OneQ16;
      t3    = (t2 * t) / OneQ16;
      tbl[r] = FRAC_W'((t3 * inner) / OneQ16);
    end
    return tbl;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();
  localparam frac_tbl_t FADE_TBL = build_fade_tbl();

endpackage

// File: design/gntc_lattice.sv
// ----------------------------------------------------------------------------
// gntc_lattice
// stages 1-3 of one noise lane: cell split, corner hashes, corner gradients
// ----------------------------------------------------------------------------
module gntc_lattice (
  input  logic                                 clk,
  input  gntc_pkg::stage_en_t                  en,
  input  logic [gntc_pkg::COORD_W-1:0]         px,
  input  logic [gntc_pkg::COORD_W-1:0]         py,
  input  logic [gntc_pkg::HASH_W-1:0]          seed_mix,
  output logic signed [gntc_pkg::NOISE_W-1:0]  n_out [4],
  output logic [gntc_pkg::FRAC_W-1:0]          sx_out,
  output logic [gntc_pkg::FRAC_W-1:0]          sy_out
);
  import gntc_pkg::*;

  logic [COORD_W-1:0] px_r, py_r;
  logic [CELL_W-1:0]  cx_r, cy_r, cx_nxt, cy_nxt;
  logic [22:0]        qx, qy;
  logic [REM_W-1:0]   rx_r, ry_r, rx_nxt, ry_nxt;
  logic [COORD_W-1:0] remx, remy;
  logic [1:0]         sel_r [4];
  logic [1:0]         sel_nxt [4];
  logic [HASH_W-1:0]  hx0, hx1, hy0, hy1;
  logic [HASH_W-1:0]  h [4];
  logic signed [NOISE_W-1:0] n_nxt [4];
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [17:0] dx [4];
  logic signed [17:0] dy [4];

  // stage 1: cell index by reciprocal multiply
  always_comb begin
    qx     = {12'b0, px} * {11'b0, DIV_RECIP};
    qy     = {12'b0, py} * {11'b0, DIV_RECIP};
    cx_nxt = qx[22:16];
    cy_nxt = qy[22:16];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      px_r <= px;
      py_r <= py;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
    end
  end

  // stage 2: remainder and corner hash select bits
  always_comb begin
    remx   = px_r - COORD_W'({4'b0, cx_r} * 11'd20);
    remy   = py_r - COORD_W'({4'b0, cy_r} * 11'd20);
    rx_nxt = remx[REM_W-1:0];
    ry_nxt = remy[REM_W-1:0];
    hx0    = HASH_W'({8'b0, cx_r} * KX);
    hx1    = HASH_W'(({8'b0, cx_r} + 15'd1) * KX);
    hy0    = HASH_W'({8'b0, cy_r} * KY);
    hy1    = HASH_W'(({8'b0, cy_r} + 15'd1) * KY);
    h[0]   = hx0 + hy0 + seed_mix;
    h[1]   = hx1 + hy0 + seed_mix;
    h[2]   = hx0 + hy1 + seed_mix;
    h[3]   = hx1 + hy1 + seed_mix;
    // low bits of the final odd multiply equal the low bits of h ^ (h >> 13)
    for (int i = 0; i < 4; i++) begin
      sel_nxt[i] = h[i][1:0] ^ h[i][HASH_SHIFT+1:HASH_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
      for (int i = 0; i < 4; i++) begin
        sel_r[i] <= sel_nxt[i];
      end
    end
  end

  // stage 3: fraction and fade lookup, corner gradients
  always_comb begin
    dx0   = $signed({1'b0, FRAC_TBL[rx_r]});
    dy0   = $signed({1'b0, FRAC_TBL[ry_r]});
    dx1   = dx0 - 18'sd65536;
    dy1   = dy0 - 18'sd65536;
    dx[0] = dx0; dy[0] = dy0;
    dx[1] = dx1; dy[1] = dy0;
    dx[2] = dx0; dy[2] = dy1;
    dx[3] = dx1; dy[3] = dy1;
    for (int i = 0; i < 4; i++) begin
      case (sel_r[i])
        2'd0:    n_nxt[i] = NOISE_W'(dx[i]) + NOISE_W'(dy[i]);
        2'd1:    n_nxt[i] = NOISE_W'(dy[i]) - NOISE_W'(dx[i]);
        2'd2:    n_nxt[i] = NOISE_W'(dx[i]) - NOISE_W'(dy[i]);
        default: n_nxt[i] = -NOISE_W'(dx[i]) - NOISE_W'(dy[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sx_out <= FADE_TBL[rx_r];
      sy_out <= FADE_TBL[ry_r];
      for (int i = 0; i < 4; i++) begin
        n_out[i] <= n_nxt[i];
      end
    end
  end

endmodule

// File: design/gntc_blend.sv
// ----------------------------------------------------------------------------
// gntc_blend
// stages 4-5 of one noise lane: bilinear blend of the corner values
// ----------------------------------------------------------------------------
module gntc_blend (
  input  logic                                 clk,
  input  gntc_pkg::stage_en_t                  en,
  input  logic signed [gntc_pkg::NOISE_W-1:0]  n_in [4],
  input  logic [gntc_pkg::FRAC_W-1:0]          sx,
  input  logic [gntc_pkg::FRAC_W-1:0]          sy,
  output logic signed [gntc_pkg::NOISE_W-1:0]  noise
);
  import gntc_pkg::*;

  logic signed [NOISE_W-1:0] ix0_r, ix1_r;
  logic [FRAC_W-1:0]         sy_r;

  // a + trunc((b - a) * s / 65536), rounding toward zero
  function automatic logic signed [NOISE_W-1:0] lerp_q(
    input logic signed [NOISE_W-1:0] a,
    input logic signed [NOISE_W-1:0] b,
    input logic [FRAC_W-1:0]         s
  );
    logic signed [NOISE_W:0]   d;
    logic signed [37:0]        p;
    logic signed [37:0]        pa;
    logic signed [21:0]        q;
    logic signed [21:0]        sum;
    d   = {b[NOISE_W-1], b} - {a[NOISE_W-1], a};
    p   = 38'(d) * 38'($signed({1'b0, s}));
    pa  = p + (p[37] ? 38'sd65535 : 38'sd0);
    q   = pa[37:16];
    sum = 22'(a) + q;
    return sum[NOISE_W-1:0];
  endfunction

  // stage 4: blend along x
  always_ff @(posedge clk) begin
    if (en.s4) begin
      ix0_r <= lerp_q(n_in[0], n_in[1], sx);
      ix1_r <= lerp_q(n_in[2], n_in[3], sx);
      sy_r  <= sy;
    end
  end

  // stage 5: blend along y
  always_ff @(posedge clk) begin
    if (en.s5) begin
      noise <= lerp_q(ix0_r, ix1_r, sy_r);
    end
  end

endmodule

// File: design/gradient_noise_terrain_classifier_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_terrain_classifier_top
// tile classifier from elevation and moisture gradient noise
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_tile_row, in_tile_col
//  out     | out_valid/out_stall| out_terrain_kind, out_elevation_noise,
//          |                    | out_moisture_noise
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// one tile per cycle while out is not stalled, result offered from the classify stage
// six register stages: cell split, hash, gradients, x blend, y blend, classify
// each stage loads when empty or when the next stage moves, so bubbles close up
// rst_n clears valid bits and sets the config registers to reset values; data registers are not reset
// in_stall is high only when every stage holds a transaction and out is stalled
module gradient_noise_terrain_classifier_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [gntc_pkg::TILE_W-1:0]          in_tile_row,
  input  logic [gntc_pkg::TILE_W-1:0]          in_tile_col,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [gntc_pkg::KIND_W-1:0]          out_terrain_kind,
  output logic signed [gntc_pkg::NOISE_W-1:0]  out_elevation_noise,
  output logic signed [gntc_pkg::NOISE_W-1:0]  out_moisture_noise,
  input  logic                                 cfg_we,
  input  logic [gntc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gntc_pkg::CFG_W-1:0]           cfg_data
);
  import gntc_pkg::*;

  logic [HASH_W-1:0]         seed_mix_r;
  logic signed [NOISE_W-1:0] sea_r, plains_r, dry_r;
  logic [4:0]                v_r;
  logic                      out_valid_r;
  logic                      en_out;
  stage_en_t                 en;
  logic [COORD_W-1:0]        ex, ey, mx, my;
  logic signed [NOISE_W-1:0] en_n [4];
  logic signed [NOISE_W-1:0] mo_n [4];
  logic [FRAC_W-1:0]         e_sx, e_sy, m_sx, m_sy;
  logic signed [NOISE_W-1:0] elev, moist;
  terrain_t                  kind_nxt, kind_r;
  logic signed [NOISE_W-1:0] elev_r, moist_r;

  // configuration registers, seed kept as its hash contribution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_mix_r <= '0;
      sea_r      <= SEA_RST;
      plains_r   <= PLAINS_RST;
      dry_r      <= DRY_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEED:   seed_mix_r <= HASH_W'(cfg_data[HASH_W-1:0] * KS);
        REG_SEA:    sea_r      <= cfg_data[NOISE_W-1:0];
        REG_PLAINS: plains_r   <= cfg_data[NOISE_W-1:0];
        REG_DRY:    dry_r      <= cfg_data[NOISE_W-1:0];
        default:    ;
      endcase
    end
  end

  // stage enables, back to front
  always_comb begin
    en_out = !out_valid_r || !out_stall;
    en.s5  = !v_r[4] || en_out;
    en.s4  = !v_r[3] || en.s5;
    en.s3  = !v_r[2] || en.s4;
    en.s2  = !v_r[1] || en.s3;
    en.s1  = !v_r[0] || en.s2;
  end

  assign in_stall = !en.s1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) v_r[0] <= in_valid;
      if (en.s2) v_r[1] <= v_r[0];
      if (en.s3) v_r[2] <= v_r[1];
      if (en.s4) v_r[3] <= v_r[2];
      if (en.s5) v_r[4] <= v_r[3];
      if (en_out) out_valid_r <= v_r[4];
    end
  end

  // sample coordinates of both lanes
  always_comb begin
    ex = {1'b0, in_tile_row};
    ey = {1'b0, in_tile_col};
    mx = ex + MOIST_OFFSET;
    my = ey + MOIST_OFFSET;
  end

  // elevation lane
  gntc_lattice u_elev_lat (
    .clk(clk), .en(en), .px(ex), .py(ey), .seed_mix(seed_mix_r),
    .n_out(en_n), .sx_out(e_sx), .sy_out(e_sy)
  );

  gntc_blend u_elev_bl (
    .clk(clk), .en(en), .n_in(en_n), .sx(e_sx), .sy(e_sy), .noise(elev)
  );

  // moisture lane
  gntc_lattice u_moist_lat (
    .clk(clk), .en(en), .px(mx), .py(my), .seed_mix(seed_mix_r),
    .n_out(mo_n), .sx_out(m_sx), .sy_out(m_sy)
  );

  gntc_blend u_moist_bl (
    .clk(clk), .en(en), .n_in(mo_n), .sx(m_sx), .sy(m_sy), .noise(moist)
  );

  // stage 6: threshold compare
  always_comb begin
    if (elev < sea_r) begin
      kind_nxt = KIND_SEA;
    end else if (elev < plains_r) begin
      kind_nxt = KIND_PLAINS;
    end else if (moist < dry_r) begin
      kind_nxt = KIND_HILLS;
    end else begin
      kind_nxt = KIND_MOUNTAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      kind_r  <= kind_nxt;
      elev_r  <= elev;
      moist_r <= moist;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_terrain_kind    = kind_r;
  assign out_elevation_noise = elev_r;
  assign out_moisture_noise  = moist_r;

endmodule

// File: design/gntc_checker.sv
// ----------------------------------------------------------------------------
// gntc_checker
// port-level checks on the terrain classifier
// ----------------------------------------------------------------------------
module gntc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [gntc_pkg::KIND_W-1:0]          out_terrain_kind,
  input logic signed [gntc_pkg::NOISE_W-1:0]  out_elevation_noise,
  input logic signed [gntc_pkg::NOISE_W-1:0]  out_moisture_noise
);
  import gntc_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_terrain_kind) &&
    $stable(out_elevation_noise) && $stable(out_moisture_noise))
    else $error("result payload changed while stalled");

  // input backpressure only when the pipeline is full behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // noise stays within plus or minus two
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elevation_noise >= -19'sd131072 &&
    out_elevation_noise <= 19'sd131072 &&
    out_moisture_noise >= -19'sd131072 && out_moisture_noise <= 19'sd131072)
    else $error("noise out of range");

endmodule

bind gradient_noise_terrain_classifier_top gntc_checker u_gntc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_terrain_kind(out_terrain_kind),
  .out_elevation_noise(out_elevation_noise), .out_moisture_noise(out_moisture_noise)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gradient noise terrain classifier: random and
// directed tiles under several register settings, checked against a local
// fixed-point predictor with random idling and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gntc_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int LATENCY    = 6;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [NOISE_W-1:0] elev;
    logic signed [NOISE_W-1:0] moist;
  } tile_class_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TILE_W-1:0] in_tile_row = '0;
  logic [TILE_W-1:0] in_tile_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] out_terrain_kind;
  logic signed [NOISE_W-1:0] out_elevation_noise;
  logic signed [NOISE_W-1:0] out_moisture_noise;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [31:0] seed_q;
  logic signed [NOISE_W-1:0] sea_q, plains_q, dry_q;

  tile_class_t expected_tiles[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit rand_stall_en = 1'b1;

  gradient_noise_terrain_classifier_top i_dut (.*);

  always #1 clk = ~clk;

  // corner gradient select from the lattice hash
  function automatic logic [1:0] lattice_sel(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] h;
    h = cx * 32'd374761393 + cy * 32'd668265263 + seed_q * 32'd362437;
    h = (h ^ 32'($signed(h) >>> 13)) * 32'd1274126177;
    return h[1:0];
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic longint fade_q(longint t);
    longint inner;
    inner = qmul(t, 6 * t - 15 * 65536) + 10 * 65536;
    return qmul(qmul(qmul(t, t), t), inner);
  endfunction

  function automatic longint grad_q(logic [1:0] sel, longint dx, longint dy);
    case (sel)
      2'd0: return dx + dy;
      2'd1: return -dx + dy;
      2'd2: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  function automatic longint gradient_noise(int px, int py);
    int cx, cy;
    longint fx, fy, sx, sy, n0, n1, n2, n3, a, b;
    cx = px / 20;
    cy = py / 20;
    fx = (longint'(px % 20) * 65536) / 20;
    fy = (longint'(py % 20) * 65536) / 20;
    sx = fade_q(fx);
    sy = fade_q(fy);
    n0 = grad_q(lattice_sel(cx, cy), fx, fy);
    n1 = grad_q(lattice_sel(cx + 1, cy), fx - 65536, fy);
    n2 = grad_q(lattice_sel(cx, cy + 1), fx, fy - 65536);
    n3 = grad_q(lattice_sel(cx + 1, cy + 1), fx - 65536, fy - 65536);
    a = n0 + qmul(n1 - n0, sx);
    b = n2 + qmul(n3 - n2, sx);
    return a + qmul(b - a, sy);
  endfunction

  function automatic tile_class_t classify_tile(int row, int col);
    tile_class_t r;
    longint e, m;
    e = gradient_noise(row, col);
    m = gradient_noise(row + 1000, col + 1000);
    if (e < sea_q) r.kind = KIND_SEA;
    else if (e < plains_q) r.kind = KIND_PLAINS;
    else if (m < dry_q) r.kind = KIND_HILLS;
    else r.kind = KIND_MOUNTAIN;
    r.elev = NOISE_W'(e);
    r.moist = NOISE_W'(m);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
  endtask

  // short gaps mostly, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // valid stays high into the next transaction when there is no gap
  task automatic send_tile(logic [TILE_W-1:0] row, logic [TILE_W-1:0] col, bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    expected_tiles.push_back(classify_tile(int'(row), int'(col)));
    in_valid <= 1'b1;
    in_tile_row <= row;
    in_tile_col <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SEED: seed_q = val;
      REG_SEA: sea_q = val[NOISE_W-1:0];
      REG_PLAINS: plains_q = val[NOISE_W-1:0];
      default: dry_q = val[NOISE_W-1:0];
    endcase
  endtask

  // all four registers back to back, write enable dropped once at the end
  task automatic write_regs(logic [31:0] seed, logic [31:0] sea, logic [31:0] plains,
                            logic [31:0] dry);
    write_reg(REG_SEED, seed);
    write_reg(REG_SEA, sea);
    write_reg(REG_PLAINS, plains);
    write_reg(REG_DRY, dry);
    cfg_we <= 1'b0;
  endtask

  task automatic random_tiles(int n, bit idle);
    for (int i = 0; i < n; i++) send_tile(TILE_W'($urandom), TILE_W'($urandom), idle);
  endtask

  // field extremes and cell borders under reset settings
  task automatic test_directed();
    send_tile(10'd0, 10'd0, 1'b0);
    send_tile(10'd1023, 10'd1023, 1'b0);
    send_tile(10'd0, 10'd1023, 1'b0);
    send_tile(10'd1023, 10'd0, 1'b0);
    send_tile(10'd19, 10'd20, 1'b0);
    send_tile(10'd20, 10'd19, 1'b0);
    send_tile(10'd10, 10'd10, 1'b0);
    send_tile(10'd1000, 10'd999, 1'b0);
    send_tile(10'h2AA, 10'h155, 1'b0);
    send_tile(10'h155, 10'h2AA, 1'b0);
    drain();
  endtask

  // seed extremes and out-of-order thresholds
  task automatic test_settings();
    write_regs(32'h7FFF_FFFF, 32'(131072), 32'(-131072), 32'(0));
    random_tiles(50, 1'b1);
    drain();
    write_regs(32'h8000_0000, 32'(-131072), 32'(-131072), 32'(131072));
    random_tiles(50, 1'b1);
    drain();
    write_regs(32'hFFFF_FFFF, 32'hFFF4_0000, 32'h0003_FFFF, 32'h0004_0000);
    random_tiles(50, 1'b1);
    drain();
  endtask

  // output held off while input keeps offering
  task automatic test_backpressure();
    rand_stall_en = 1'b0;
    hold_off = 1'b1;
    random_tiles(40, 1'b0);
    hold_off = 1'b0;
    rand_stall_en = 1'b1;
    drain();
  endtask

  // random seeds and thresholds, random tiles
  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_regs($urandom, 32'($signed($urandom_range(60000)) - 45000),
                 32'($signed($urandom_range(60000)) - 15000),
                 ph[0] ? $urandom : 32'($signed($urandom_range(60000)) - 30000));
      random_tiles(100, ph != 3);
      drain();
    end
  endtask

  // receiver stall: random gaps, long hold-off when asked
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if (rand_stall_en) begin
        g = gap_len();
        out_stall <= (g != 0);
        repeat (g) @(posedge clk);
        if (g != 0) out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    tile_class_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tiles.size() == 0) begin
        errors++;
        $display("unexpected result transaction");
      end else begin
        w = expected_tiles.pop_front();
        if (out_terrain_kind !== w.kind)
          report("terrain_kind", longint'(out_terrain_kind), longint'(w.kind));
        if (out_elevation_noise !== w.elev)
          report("elevation_noise", longint'(out_elevation_noise), longint'(w.elev));
        if (out_moisture_noise !== w.moist)
          report("moisture_noise", longint'(out_moisture_noise), longint'(w.moist));
        checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    seed_q = '0;
    sea_q = SEA_RST;
    plains_q = PLAINS_RST;
    dry_q = DRY_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    test_random();
    if (expected_tiles.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_tiles.size());
    end
    $display("covered %0d tiles over directed, extreme-setting, stall and random phases",
             checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
